// ===== rtl/qrv_pkg.sv =====
// ----------------------------------------------------------------------------
// qrv_pkg
// shared constants for the quaternion vector rotation block
// ----------------------------------------------------------------------------
package qrv_pkg;

    // normalized quaternion: two's complement, Q2.15 (Q1.15 magnitude), magnitude up to 1.0
    localparam int NORM_FRAC  = 15;
    localparam int MAG_BITS   = 16;
    localparam int NORM_W     = MAG_BITS + 1;
    localparam int ONE_Q15    = 1 << NORM_FRAC;
    localparam int ROUND_HALF = 1 << (NORM_FRAC - 1);

    // default field widths
    localparam int DEF_VEC_WIDTH  = 32;
    localparam int DEF_QUAT_WIDTH = 16;

    // queue between front and back
    localparam int QUEUE_AW    = 5;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

endpackage

// ===== rtl/qrv_front.sv =====
// ----------------------------------------------------------------------------
// qrv_front
// quaternion normalization: sum of squares, then one magnitude bit per stage
// ----------------------------------------------------------------------------
module qrv_front #(
    parameter int QW = qrv_pkg::DEF_QUAT_WIDTH,
    parameter int VW = qrv_pkg::DEF_VEC_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  logic [3:0][QW-1:0]                   in_quat,
    input  logic [2:0][VW-1:0]                   in_vec,
    output logic                                 out_valid,
    output logic [3:0][qrv_pkg::NORM_W-1:0]      out_norm,
    output logic [2:0][VW-1:0]                   out_vec
);
    import qrv_pkg::*;

    localparam int SQW = 2 * QW;
    localparam int SW  = 2 * QW + 2;
    localparam int RW  = SQW + 2 * NORM_FRAC;
    localparam int PW  = SW + 2 * MAG_BITS + 1;
    localparam int QQW = SW + MAG_BITS + 1;
    localparam int NS  = MAG_BITS;

    // stage a: magnitudes and squares
    logic              va_reg;
    logic [QW-1:0]     a_reg   [0:3];
    logic              sgn_a_reg [0:3];
    logic [SQW-1:0]    sq_reg  [0:3];
    logic [VW-1:0]     vec_a_reg [0:2];

    // normalization stages, index 0 holds the stage b result
    logic              st_valid_reg [0:NS];
    logic [SW-1:0]     st_s_reg     [0:NS];
    logic              st_zero_reg  [0:NS];
    logic              st_sgn_reg   [0:NS][0:3];
    logic [RW-1:0]     st_r_reg     [0:NS][0:3];
    logic [PW-1:0]     st_p_reg     [0:NS][0:3];
    logic [QQW-1:0]    st_q_reg     [0:NS][0:3];
    logic [MAG_BITS-1:0] st_m_reg   [0:NS][0:3];
    logic [VW-1:0]     st_vec_reg   [0:NS][0:2];

    logic [QW-1:0]     abs_next [0:3];
    logic [SW-1:0]     sum_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            abs_next[i] = in_quat[i][QW-1] ? (~in_quat[i] + QW'(1)) : in_quat[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else begin
            va_reg <= in_valid;
        end
        for (int i = 0; i < 4; i++) begin
            a_reg[i]     <= abs_next[i];
            sgn_a_reg[i] <= in_quat[i][QW-1];
            sq_reg[i]    <= abs_next[i] * abs_next[i];
        end
        for (int j = 0; j < 3; j++) begin
            vec_a_reg[j] <= in_vec[j];
        end
    end

    assign sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);

    // stage b: sum of squares, targets a^2 * 2^30
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg[0] <= 1'b0;
        end else begin
            st_valid_reg[0] <= va_reg;
        end
        st_s_reg[0]    <= sum_next;
        st_zero_reg[0] <= (sum_next == '0);
        for (int i = 0; i < 4; i++) begin
            st_sgn_reg[0][i] <= sgn_a_reg[i];
            st_r_reg[0][i]   <= RW'(sq_reg[i]) << (2 * NORM_FRAC);
            st_p_reg[0][i]   <= '0;
            st_q_reg[0][i]   <= '0;
            st_m_reg[0][i]   <= '0;
        end
        for (int j = 0; j < 3; j++) begin
            st_vec_reg[0][j] <= vec_a_reg[j];
        end
    end

    // stage k decides magnitude bit MAG_BITS-k; p = m^2*S, q = m*S kept incrementally
    for (genvar k = 1; k <= NS; k++) begin : g_stage
        localparam int B = MAG_BITS - k;
        logic [PW-1:0] cand [0:3];
        logic          take [0:3];

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                cand[i] = st_p_reg[k-1][i]
                        + (PW'(st_q_reg[k-1][i]) << (B + 1))
                        + (PW'(st_s_reg[k-1]) << (2 * B));
                take[i] = (cand[i] <= PW'(st_r_reg[k-1][i]));
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_valid_reg[k] <= 1'b0;
            end else begin
                st_valid_reg[k] <= st_valid_reg[k-1];
            end
            st_s_reg[k]    <= st_s_reg[k-1];
            st_zero_reg[k] <= st_zero_reg[k-1];
            for (int i = 0; i < 4; i++) begin
                st_sgn_reg[k][i] <= st_sgn_reg[k-1][i];
                st_r_reg[k][i]   <= st_r_reg[k-1][i];
                if (take[i]) begin
                    st_p_reg[k][i] <= cand[i];
                    st_q_reg[k][i] <= st_q_reg[k-1][i] + (QQW'(st_s_reg[k-1]) << B);
                    st_m_reg[k][i] <= st_m_reg[k-1][i] | (MAG_BITS'(1) << B);
                end else begin
                    st_p_reg[k][i] <= st_p_reg[k-1][i];
                    st_q_reg[k][i] <= st_q_reg[k-1][i];
                    st_m_reg[k][i] <= st_m_reg[k-1][i];
                end
            end
            for (int j = 0; j < 3; j++) begin
                st_vec_reg[k][j] <= st_vec_reg[k-1][j];
            end
        end
    end

    // signed result, identity for a zero quaternion
    always_comb begin
        out_valid = st_valid_reg[NS];
        for (int i = 0; i < 4; i++) begin
            if (st_zero_reg[NS]) begin
                out_norm[i] = (i == 3) ? NORM_W'(ONE_Q15) : '0;
            end else if (st_sgn_reg[NS][i]) begin
                out_norm[i] = ~{1'b0, st_m_reg[NS][i]} + NORM_W'(1);
            end else begin
                out_norm[i] = {1'b0, st_m_reg[NS][i]};
            end
        end
        for (int j = 0; j < 3; j++) begin
            out_vec[j] = st_vec_reg[NS][j];
        end
    end

endmodule

// ===== rtl/qrv_queue.sv =====
// ----------------------------------------------------------------------------
// qrv_queue
// small first-in first-out queue between normalization and rotation
// ----------------------------------------------------------------------------
module qrv_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    output logic [DW-1:0] rd_data,
    output logic          empty
);
    import qrv_pkg::*;

    logic [DW-1:0]       mem_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            fill_reg <= fill_reg + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
        end
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign empty   = (fill_reg == '0);

endmodule

// ===== rtl/qrv_back.sv =====
// ----------------------------------------------------------------------------
// qrv_back
// rotation n * v * conj(n) as two registered hamilton products
// ----------------------------------------------------------------------------
module qrv_back #(
    parameter int VW = qrv_pkg::DEF_VEC_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_avail,
    output logic                              in_pop,
    input  logic [3:0][qrv_pkg::NORM_W-1:0]   in_norm,
    input  logic [2:0][VW-1:0]                in_vec,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0][VW-1:0]                out_rot,
    output logic                              out_clip
);
    import qrv_pkg::*;

    localparam int P1W = VW + NORM_W;
    localparam int S1W = P1W + 3;
    localparam int TW  = S1W - NORM_FRAC;
    localparam int P2W = TW + NORM_W;
    localparam int S2W = P2W + 3;
    localparam int RW  = S2W - NORM_FRAC;

    logic en;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [P1W-1:0]    p1_reg [0:11];
    logic signed [NORM_W-1:0] n1_reg [0:3];
    logic signed [NORM_W-1:0] n2_reg [0:3];
    logic signed [TW-1:0]     t_reg  [0:3];
    logic signed [P2W-1:0]    p2_reg [0:11];
    logic [2:0][VW-1:0]       rot_reg;
    logic                     clip_reg;

    logic signed [NORM_W-1:0] n [0:3];
    logic signed [VW-1:0]     v [0:2];
    logic signed [S1W-1:0]    s1 [0:3];
    logic signed [S2W-1:0]    s2 [0:2];
    logic signed [RW-1:0]     r  [0:2];
    logic [2:0][VW-1:0]       sat;
    logic [2:0]               ovf;

    assign en     = !v4_reg || out_ready;
    assign in_pop = en && in_avail;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n[i] = in_norm[i];
        end
        for (int j = 0; j < 3; j++) begin
            v[j] = in_vec[j];
        end
    end

    // first product: t = n * (v, 0), with n = (x, y, z, w) at indices 0..3
    always_comb begin
        s1[0] = -p1_reg[0] - p1_reg[1] - p1_reg[2];
        s1[1] =  p1_reg[3] + p1_reg[4] - p1_reg[5];
        s1[2] =  p1_reg[6] - p1_reg[7] + p1_reg[8];
        s1[3] =  p1_reg[9] + p1_reg[10] - p1_reg[11];
        for (int i = 0; i < 4; i++) begin
            s1[i] = s1[i] + S1W'(ROUND_HALF);
        end
    end

    // second product: r = t * conj(n), t = (tw, tx, ty, tz) at indices 0..3
    always_comb begin
        s2[0] = -p2_reg[0] + p2_reg[1] - p2_reg[2]  + p2_reg[3];
        s2[1] = -p2_reg[4] + p2_reg[5] + p2_reg[6]  - p2_reg[7];
        s2[2] = -p2_reg[8] - p2_reg[9] + p2_reg[10] + p2_reg[11];
        for (int j = 0; j < 3; j++) begin
            s2[j] = s2[j] + S2W'(ROUND_HALF);
            r[j]  = s2[j][S2W-1:NORM_FRAC];
            ovf[j] = (r[j][RW-1:VW-1] != '0) && (r[j][RW-1:VW-1] != '1);
            if (!ovf[j]) begin
                sat[j] = r[j][VW-1:0];
            end else if (r[j][RW-1]) begin
                sat[j] = {1'b1, {(VW-1){1'b0}}};
            end else begin
                sat[j] = {1'b0, {(VW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_avail;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
        if (en) begin
            p1_reg[0]  <= n[0] * v[0];
            p1_reg[1]  <= n[1] * v[1];
            p1_reg[2]  <= n[2] * v[2];
            p1_reg[3]  <= n[3] * v[0];
            p1_reg[4]  <= n[1] * v[2];
            p1_reg[5]  <= n[2] * v[1];
            p1_reg[6]  <= n[3] * v[1];
            p1_reg[7]  <= n[0] * v[2];
            p1_reg[8]  <= n[2] * v[0];
            p1_reg[9]  <= n[3] * v[2];
            p1_reg[10] <= n[0] * v[1];
            p1_reg[11] <= n[1] * v[0];
            for (int i = 0; i < 4; i++) begin
                n1_reg[i] <= n[i];
                n2_reg[i] <= n1_reg[i];
                t_reg[i]  <= s1[i][S1W-1:NORM_FRAC];
            end
            p2_reg[0]  <= t_reg[0] * n2_reg[0];
            p2_reg[1]  <= t_reg[1] * n2_reg[3];
            p2_reg[2]  <= t_reg[2] * n2_reg[2];
            p2_reg[3]  <= t_reg[3] * n2_reg[1];
            p2_reg[4]  <= t_reg[0] * n2_reg[1];
            p2_reg[5]  <= t_reg[1] * n2_reg[2];
            p2_reg[6]  <= t_reg[2] * n2_reg[3];
            p2_reg[7]  <= t_reg[3] * n2_reg[0];
            p2_reg[8]  <= t_reg[0] * n2_reg[2];
            p2_reg[9]  <= t_reg[1] * n2_reg[1];
            p2_reg[10] <= t_reg[2] * n2_reg[0];
            p2_reg[11] <= t_reg[3] * n2_reg[3];
            rot_reg    <= sat;
            clip_reg   <= |ovf;
        end
    end

    assign out_valid = v4_reg;
    assign out_rot   = rot_reg;
    assign out_clip  = clip_reg;

endmodule

// ===== rtl/quaternion_rotate_vector_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_top
// rotates a q16.16 vector by a quaternion of any scale, with saturation
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (lsb first)                         | tuser
//  s_       | in        | quat_x, quat_y, quat_z, quat_w, vec_x,y,z | -
//  m_       | out       | rot_x, rot_y, rot_z                       | clipped
//
//  one item per cycle sustained while s_tready and m_tready stay high; an item
//  passes through normalization (squares, sum, then one magnitude bit per stage),
//  the queue and rotation (two multiply and round stages for each product)
//  reset is synchronous, active low, and empties every stage and the queue
//  the normalization pipe never stalls: s_tready drops only when items in
//  flight plus queued items reach the queue depth; m_tready low holds the
//  rotation pipe while the front keeps filling the queue
// ----------------------------------------------------------------------------
module quaternion_rotate_vector_top #(
    parameter int VEC_WIDTH  = qrv_pkg::DEF_VEC_WIDTH,
    parameter int QUAT_WIDTH = qrv_pkg::DEF_QUAT_WIDTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, zero fill
    input  logic [((4*QUAT_WIDTH+3*VEC_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // rot_x, rot_y, rot_z, zero fill
    output logic [((3*VEC_WIDTH+7)/8)*8-1:0] m_tdata,
    // clipped
    output logic [0:0] m_tuser
);
    import qrv_pkg::*;

    localparam int QW      = QUAT_WIDTH;
    localparam int VW      = VEC_WIDTH;
    localparam int OUT_W   = ((3*VW+7)/8)*8;
    localparam int ITEM_W  = 4*NORM_W + 3*VW;

    logic                     s_acc;
    logic [3:0][QW-1:0]       quat;
    logic [2:0][VW-1:0]       vec;

    logic                     fr_valid;
    logic [3:0][NORM_W-1:0]   fr_norm;
    logic [2:0][VW-1:0]       fr_vec;

    logic [ITEM_W-1:0]        q_rd_data;
    logic                     q_empty;
    logic                     q_pop;

    logic [2:0][VW-1:0]       rot;
    logic                     clip;

    // items in normalization pipe or queue
    logic [QUEUE_AW:0]        credit_reg;

    assign s_tready = (credit_reg < (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign s_acc    = s_tvalid && s_tready;

    // unpack the input item
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            quat[i] = s_tdata[i*QW +: QW];
        end
        for (int j = 0; j < 3; j++) begin
            vec[j] = s_tdata[4*QW + j*VW +: VW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_reg + (QUEUE_AW+1)'(s_acc) - (QUEUE_AW+1)'(q_pop);
        end
    end

    qrv_front #(
        .QW (QW),
        .VW (VW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_acc),
        .in_quat   (quat),
        .in_vec    (vec),
        .out_valid (fr_valid),
        .out_norm  (fr_norm),
        .out_vec   (fr_vec)
    );

    qrv_queue #(
        .DW (ITEM_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (fr_valid),
        .wr_data ({fr_norm, fr_vec}),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    qrv_back #(
        .VW (VW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_avail  (!q_empty),
        .in_pop    (q_pop),
        .in_norm   (q_rd_data[ITEM_W-1:3*VW]),
        .in_vec    (q_rd_data[3*VW-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rot   (rot),
        .out_clip  (clip)
    );

    // results packed x first, clip flag on tuser
    assign m_tdata = OUT_W'(rot);
    assign m_tuser = clip;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for quaternion_rotate_vector_top: drives quaternion and
// vector items, predicts each rotated, saturated vector and compares results
// in order, under several idle and stall patterns and one long output stall
// ----------------------------------------------------------------------------
module testbench;
    import qrv_pkg::*;

    localparam int QW     = 16;
    localparam int VW     = 32;
    localparam int S_BITS = 160;
    localparam int M_BITS = 96;
    localparam int LIMIT  = 400000;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic                 clipped;
    } rot_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [M_BITS-1:0] m_tdata;
    logic [0:0]        m_tuser;

    rot_t expected_rot[$];
    int   fail_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;

    quaternion_rotate_vector_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // rot_x, rot_y, rot_z
        .m_tdata  (m_tdata),
        // clipped
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // largest m with m^2 * sum_sq <= mag^2 * 2^30, i.e. floor(mag * 2^15 / norm)
    function automatic longint norm_mag(longint unsigned mag, longint unsigned sum_sq);
        bit [127:0] lim;
        bit [127:0] cand;
        longint     m;
        lim = (128'(mag) * 128'(mag)) << 30;
        m = 0;
        for (int b = 15; b >= 0; b--) begin
            cand = 128'(m | (64'd1 << b));
            if (cand * cand * 128'(sum_sq) <= lim)
                m = m | (64'd1 << b);
        end
        return m;
    endfunction

    // round to nearest, ties up, by 2^15
    function automatic longint rnd15(longint v);
        return (v + ROUND_HALF) >>> NORM_FRAC;
    endfunction

    function automatic rot_t rotate_predict(logic [S_BITS-1:0] d);
        longint          q[4];
        longint          n[4];
        longint          v[3];
        longint          r[3];
        longint          tw, tx, ty, tz;
        longint          lim;
        longint unsigned mag;
        longint unsigned sum_sq;
        rot_t            res;
        sum_sq = 0;
        for (int i = 0; i < 4; i++) begin
            q[i] = longint'($signed(d[i*QW +: QW]));
            mag = (q[i] < 0) ? -q[i] : q[i];
            sum_sq += mag * mag;
        end
        for (int i = 0; i < 3; i++)
            v[i] = longint'($signed(d[4*QW + i*VW +: VW]));
        if (sum_sq == 0) begin
            n[0] = 0; n[1] = 0; n[2] = 0; n[3] = ONE_Q15;
        end else begin
            for (int i = 0; i < 4; i++) begin
                mag = (q[i] < 0) ? -q[i] : q[i];
                n[i] = (q[i] < 0) ? -norm_mag(mag, sum_sq) : norm_mag(mag, sum_sq);
            end
        end
        tw = rnd15(-n[0] * v[0] - n[1] * v[1] - n[2] * v[2]);
        tx = rnd15(n[3] * v[0] + n[1] * v[2] - n[2] * v[1]);
        ty = rnd15(n[3] * v[1] - n[0] * v[2] + n[2] * v[0]);
        tz = rnd15(n[3] * v[2] + n[0] * v[1] - n[1] * v[0]);
        r[0] = rnd15(-tw * n[0] + tx * n[3] - ty * n[2] + tz * n[1]);
        r[1] = rnd15(-tw * n[1] + tx * n[2] + ty * n[3] - tz * n[0]);
        r[2] = rnd15(-tw * n[2] - tx * n[1] + ty * n[0] + tz * n[3]);
        lim = (64'sd1 <<< (VW - 1)) - 1;
        res.clipped = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r[i] > lim) begin
                r[i] = lim; res.clipped = 1'b1;
            end else if (r[i] < -lim - 1) begin
                r[i] = -lim - 1; res.clipped = 1'b1;
            end
        end
        res.x = r[0][VW-1:0];
        res.y = r[1][VW-1:0];
        res.z = r[2][VW-1:0];
        return res;
    endfunction

    task automatic report(string what, logic [VW-1:0] got, logic [VW-1:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    // every accepted input item queues its expected rotation
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_rot.push_back(rotate_predict(s_tdata));
    end

    // result checker, oldest expectation first
    always @(posedge aclk) begin
        rot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rot.size() == 0) begin
                $display("unexpected result item at cycle %0d", cycle_count);
                fail_count++;
            end else begin
                want = expected_rot.pop_front();
                if (m_tdata[0 +: VW] !== want.x) report("rot_x", m_tdata[0 +: VW], want.x);
                if (m_tdata[VW +: VW] !== want.y) report("rot_y", m_tdata[VW +: VW], want.y);
                if (m_tdata[2*VW +: VW] !== want.z)
                    report("rot_z", m_tdata[2*VW +: VW], want.z);
                if (m_tuser[0] !== want.clipped)
                    report("clipped", VW'(m_tuser[0]), VW'(want.clipped));
            end
        end
    end

    // receiver: random stalls, forced low during a hold-off
    always @(negedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one item from a falling edge, leave at the falling edge after acceptance
    task automatic send_item(logic [S_BITS-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [S_BITS-1:0] pack_item(logic [QW-1:0] qx, logic [QW-1:0] qy,
        logic [QW-1:0] qz, logic [QW-1:0] qw, logic [VW-1:0] vx, logic [VW-1:0] vy,
        logic [VW-1:0] vz);
        return {vz, vy, vx, qw, qz, qy, qx};
    endfunction

    function automatic logic [QW-1:0] rand_quat_part();
        case ($urandom_range(3))
            0: return QW'($urandom);
            1: return QW'($signed($urandom_range(16)) - 8);
            2: return QW'($signed($urandom_range(2000)) - 1000);
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [VW-1:0] rand_vec_part();
        case ($urandom_range(3))
            0: return VW'($urandom);
            1: return VW'($signed($urandom_range(2000000)) - 1000000);
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return VW'($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    // extremes, zero quaternion, single axes, most negative values, saturation
    task automatic test_directed();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_item(pack_item(0, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000));
        send_item(pack_item(0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0));
        send_item(pack_item(0, 0, 0, 1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        send_item(pack_item(0, 0, 0, 16'h8000, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff));
        send_item(pack_item(16'h7fff, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        send_item(pack_item(0, 16'h8000, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        send_item(pack_item(0, 0, 5, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001));
        send_item(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(pack_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        // rotations of full-scale vectors, then of small vectors
        send_item(pack_item(0, 0, 1, 1, 32'h7fff_ffff, 32'h7fff_ffff, 0));
        send_item(pack_item(1, 0, 0, 1, 0, 32'h8000_0000, 32'h8000_0000));
        send_item(pack_item(1, 1, 1, 1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_item(pack_item(16'hffff, 2, 16'hfffd, 4, 32'hffff_ffff, 1, 0));
        send_item(pack_item(16'h0001, 16'hffff, 0, 0, 32'h0000_8000, 32'hffff_8000, 1));
        send_item(pack_item(3, 4, 0, 0, 32'h0005_0000, 0, 32'hfffb_0000));
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct; recv_stall_pct = stall_pct;
        repeat (count)
            send_item(pack_item(rand_quat_part(), rand_quat_part(), rand_quat_part(),
                                rand_quat_part(), rand_vec_part(), rand_vec_part(),
                                rand_vec_part()));
    endtask

    // receiver holds off long enough for the queue to fill and s_tready to drop
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (150) @(posedge aclk);
                hold_off = 1'b0;
            end
        join_none
        test_random(70, 0, 0);
    endtask

    initial begin
        fail_count = 0; cycle_count = 0; hold_off = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(100, 0, 0);
        test_random(90, 58, 0);
        test_random(90, 0, 58);
        test_random(90, 10, 10);
        test_backpressure();
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_rot.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/qrv_pkg.sv
rtl/qrv_front.sv
rtl/qrv_queue.sv
rtl/qrv_back.sv
rtl/quaternion_rotate_vector_top.sv
test/testbench.sv
